// ===== rtl/rlepx_pkg.sv =====
// shared types and constants of the tga run-length pixel decoder
// no dependencies; imported by every module of the decoder
package rlepx_pkg;

  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned HDR_REPEAT_B  = 7;
  localparam logic [6:0]  HDR_LEN_MASK  = 7'h7f;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_HAS_ALPHA    = 1'b0,
    REG_IMAGE_PIXELS = 1'b1
  } reg_idx_t;

  // configuration seen by the front end
  typedef struct packed {
    logic        has_alpha;
    logic [31:0] image_pixels;
  } cfg_t;

  // one finished pixel as it travels from front end to back end
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       has_alpha;
    logic [7:0] count;
    logic       last;
    logic       over;
  } pix_rec_t;

endpackage

// ===== rtl/rlepx_front.sv =====
// front end: packet header parsing, pixel byte collection, image pixel count
// depends on rlepx_pkg
module rlepx_front (
  input  logic                clk,
  input  logic                rst,
  input  rlepx_pkg::cfg_t     cfg,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  output logic                rec_push,
  output rlepx_pkg::pix_rec_t rec
);
  import rlepx_pkg::*;

  logic        in_body, in_body_next;
  logic        rep_pkt, rep_pkt_next;
  logic [7:0]  pkt_left, pkt_left_next;
  logic [1:0]  ch_idx, ch_idx_next;
  logic [7:0]  ch_bytes [3];
  logic [31:0] img_left, img_left_next;

  logic [1:0]  last_pos;
  logic        final_byte;
  logic        rep_ge;
  logic [7:0]  rep_count;
  logic        raw_last;
  logic [7:0]  raw_pkt_dec;

  always_comb begin
    last_pos    = cfg.has_alpha ? 2'd3 : 2'd2;
    final_byte  = in_body && (ch_idx >= last_pos);
    rep_ge      = {24'd0, pkt_left} >= img_left;
    rep_count   = rep_ge ? img_left[7:0] : pkt_left;
    raw_last    = (img_left[31:1] == 31'd0);
    raw_pkt_dec = (pkt_left != 8'd0) ? pkt_left - 8'd1 : 8'd0;
  end

  always_comb begin
    in_body_next  = in_body;
    rep_pkt_next  = rep_pkt;
    pkt_left_next = pkt_left;
    ch_idx_next   = ch_idx;
    img_left_next = img_left;
    if (accept) begin
      if (!in_body) begin
        if (img_left == 32'd0) begin
          img_left_next = (cfg.image_pixels != 32'd0) ? cfg.image_pixels : 32'd1;
        end
        rep_pkt_next  = data_byte[HDR_REPEAT_B];
        pkt_left_next = {1'b0, data_byte[6:0] & HDR_LEN_MASK} + 8'd1;
        ch_idx_next   = 2'd0;
        in_body_next  = 1'b1;
      end else if (!final_byte) begin
        ch_idx_next = ch_idx + 2'd1;
      end else begin
        ch_idx_next = 2'd0;
        if (rep_pkt) begin
          img_left_next = img_left - {24'd0, rep_count};
          pkt_left_next = 8'd0;
          in_body_next  = 1'b0;
        end else begin
          img_left_next = raw_last ? 32'd0 : img_left - 32'd1;
          pkt_left_next = raw_pkt_dec;
          if (raw_pkt_dec == 8'd0 || raw_last) begin
            pkt_left_next = 8'd0;
            in_body_next  = 1'b0;
          end
        end
      end
    end
  end

  // result record for the final byte of a pixel
  always_comb begin
    rec_push      = accept && final_byte;
    rec.byte0     = ch_bytes[0];
    rec.byte1     = ch_bytes[1];
    rec.byte2     = ch_bytes[2];
    rec.byte3     = data_byte;
    rec.has_alpha = cfg.has_alpha;
    if (rep_pkt) begin
      rec.count = rep_count;
      rec.last  = rep_ge;
      rec.over  = {24'd0, pkt_left} > img_left;
    end else begin
      rec.count = 8'd1;
      rec.last  = raw_last;
      rec.over  = raw_last && (pkt_left > 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body     <= 1'b0;
      rep_pkt     <= 1'b0;
      pkt_left    <= 8'd0;
      ch_idx      <= 2'd0;
      img_left    <= 32'd0;
      ch_bytes[0] <= 8'd0;
      ch_bytes[1] <= 8'd0;
      ch_bytes[2] <= 8'd0;
    end else begin
      in_body  <= in_body_next;
      rep_pkt  <= rep_pkt_next;
      pkt_left <= pkt_left_next;
      ch_idx   <= ch_idx_next;
      img_left <= img_left_next;
      if (accept && in_body && !final_byte) begin
        ch_bytes[ch_idx] <= data_byte;
      end
    end
  end

endmodule

// ===== rtl/rlepx_queue.sv =====
// small queue of pixel records between front end and back end
// depends on rlepx_pkg
module rlepx_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  rlepx_pkg::pix_rec_t wr_data,
  input  logic                rd_en,
  output rlepx_pkg::pix_rec_t rd_data,
  output logic                full,
  output logic                nonempty
);
  import rlepx_pkg::*;

  pix_rec_t               entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rlepx_back.sv =====
// back end: channel reorder to rgb and the result output register
// depends on rlepx_pkg
module rlepx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nonempty,
  input  rlepx_pkg::pix_rec_t q_data,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha,
  output logic [7:0]          repeat_count,
  output logic                last_pixel,
  output logic                overrun
);
  import rlepx_pkg::*;

  logic out_valid;

  assign empty = !out_valid;
  assign q_pop = q_nonempty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      blue         <= q_data.byte0;
      green        <= q_data.byte1;
      red          <= q_data.has_alpha ? q_data.byte2 : q_data.byte3;
      alpha        <= q_data.has_alpha ? q_data.byte3 : 8'd0;
      repeat_count <= q_data.count;
      last_pixel   <= q_data.last;
      overrun      <= q_data.over;
    end
  end

endmodule

// ===== rtl/tga_rle_pixel_decoder.sv =====
// tga run-length pixel decoder, top level; depends on rlepx_pkg, rlepx_front,
// rlepx_queue and rlepx_back
// a pixel's record is queued as its final byte is taken, then registered at the output
// throughput: one byte per cycle while full is low; full rises only when the 4-entry pixel queue is full
// reset (rst, synchronous): parser waits for a packet header, image count reloads at
// the first header, queue and output register empty, has_alpha = 1, image_pixels = 1
module tga_rle_pixel_decoder (
  input  logic                        clk,
  input  logic                        rst,
  // byte stream in
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  data_byte,
  // pixel results out
  input  logic                        pop,
  output logic                        empty,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [7:0]                  alpha,
  output logic [7:0]                  repeat_count,
  output logic                        last_pixel,
  output logic                        overrun,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlepx_pkg::ADDR_W-1:0] paddr,
  input  logic [rlepx_pkg::DATA_W-1:0] pwdata,
  output logic [rlepx_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rlepx_pkg::*;

  // configuration registers
  logic     has_alpha;
  logic [31:0] image_pixels;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  cfg_t     cfg;

  // front end to queue to back end
  logic     in_accept;
  logic     rec_push;
  pix_rec_t rec;
  pix_rec_t q_data;
  logic     q_full;
  logic     q_nonempty;
  logic     q_pop;

  // register i sits at byte address 4*i; low address bits are ignored
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_alpha    <= 1'b1;
      image_pixels <= 32'd1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_HAS_ALPHA:    has_alpha    <= pwdata[0];
        REG_IMAGE_PIXELS: image_pixels <= pwdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HAS_ALPHA:    prdata = {{(DATA_W-1){1'b0}}, has_alpha};
      REG_IMAGE_PIXELS: prdata = image_pixels;
      default:          prdata = '0;
    endcase
  end

  assign cfg.has_alpha    = has_alpha;
  assign cfg.image_pixels = image_pixels;

  // a byte is taken whenever the queue has room; header and channel bytes
  // make no record, yet every byte is held while the queue is full
  assign full      = q_full;
  assign in_accept = push && !full;

  // front end: packet parsing and image pixel count, one byte per cycle while the queue has room
  rlepx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (in_accept),
    .data_byte (data_byte),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // decoupling queue so output stalls do not stop the byte stream at once
  rlepx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_data  (rec),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // back end: rgb reorder into the output register, refilled as it drains
  rlepx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_pixel   (last_pixel),
    .overrun      (overrun)
  );

  // a clipped run always ends the image
  assert property (@(posedge clk) disable iff (rst)
    (!empty && overrun) |-> last_pixel)
    else $error("overrun without last_pixel");

  // every transaction on the result side covers at least one pixel
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (repeat_count != 8'd0))
    else $error("zero repeat_count on result");

  // the queue is never written while it reports full
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> !rec_push)
    else $error("pixel record pushed into full queue");

  // a record leaving the queue reaches the output register on the next edge
  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !empty)
    else $error("popped record lost before output register");

endmodule
